### hw/rtl/tcos_pkg.sv
`timescale 1ns / 1ps
// shared widths, constants, coefficient table and stage bus types for the cosine unit
package tcos_pkg;

  localparam int TERMS      = 5;
  localparam int COEF_COUNT = 8;
  localparam int NT         = (TERMS < COEF_COUNT) ? TERMS : COEF_COUNT;
  localparam int LAST_K     = NT - 1;
  localparam int KW         = 3;

  localparam int ANGLE_W = 20;
  localparam int ABS_W   = 16;
  localparam int SQ_W    = 32;
  localparam int X2_W    = 18;
  localparam int P_W     = 38;
  localparam int C_W     = 41;
  localparam int T_W     = 58;
  localparam int ACC_W   = 60;
  localparam int FRAC_SH = 40;
  localparam int RES_W   = ACC_W - FRAC_SH;
  localparam int COS_W   = 16;

  localparam logic signed [ANGLE_W-1:0] Q14_PI     = 20'sd51472;
  localparam logic signed [ANGLE_W-1:0] Q14_TWO_PI = 20'sd102944;
  localparam logic [X2_W-1:0]           X2_MAX     = 18'd161708;
  localparam logic signed [ACC_W-1:0]   ACC_INIT   = 60'sd18014398509481984;
  localparam logic signed [ACC_W-1:0]   ACC_HALF   = 60'sd549755813888;
  localparam logic signed [RES_W-1:0]   COS_MAX    = 20'sd32767;
  localparam logic signed [RES_W-1:0]   COS_MIN    = -20'sd32768;

  typedef struct packed {
    logic                      valid;
    logic signed [ANGLE_W-1:0] a;
  } fold_bus_t;

  typedef struct packed {
    logic                    valid;
    logic [X2_W-1:0]         x2;
    logic [P_W-1:0]          p;
    logic [T_W-1:0]          t;
    logic signed [ACC_W-1:0] acc;
  } term_bus_t;

  // 1/(2k)! in q40
  function automatic logic [C_W-1:0] coef(input logic [KW-1:0] k);
    logic [C_W-1:0] c;
    case (k)
      3'd0: c = 41'd1099511627776;
      3'd1: c = 41'd549755813888;
      3'd2: c = 41'd45812984491;
      3'd3: c = 41'd1527099483;
      3'd4: c = 41'd27269634;
      3'd5: c = 41'd302996;
      3'd6: c = 41'd2295;
      3'd7: c = 41'd13;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/tcos_fold.sv
`timescale 1ns / 1ps
// range reduction stage: three conditional steps of 2*pi towards minus pi to pi
module tcos_fold import tcos_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  fold_bus_t bus_in,
  output fold_bus_t bus_out
);

  logic                      valid;
  logic signed [ANGLE_W-1:0] a;
  logic signed [ANGLE_W-1:0] a_next;

  always_comb begin
    logic signed [ANGLE_W-1:0] w;
    w = bus_in.a;
    for (int i = 0; i < 3; i++) begin
      if (w > Q14_PI) begin
        w = w - Q14_TWO_PI;
      end else if (w < -Q14_PI) begin
        w = w + Q14_TWO_PI;
      end
    end
    a_next = w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= bus_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a <= a_next;
    end
  end

  assign bus_out = '{valid: valid, a: a};

endmodule

### hw/rtl/tcos_square.sv
`timescale 1ns / 1ps
// squaring stages: |x|^2, then rounding to q14 and seeding the series bus
module tcos_square import tcos_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  fold_bus_t bus_in,
  output term_bus_t bus_out
);

  logic                      sq_valid;
  logic [SQ_W-1:0]           sq;
  logic [ABS_W-1:0]          ax;
  logic signed [ANGLE_W-1:0] neg_a;
  logic [SQ_W-1:0]           sq_rnd;
  logic                      x2_valid;
  logic [X2_W-1:0]           x2;

  assign neg_a  = -bus_in.a;
  assign ax     = bus_in.a[ANGLE_W-1] ? neg_a[ABS_W-1:0] : bus_in.a[ABS_W-1:0];
  assign sq_rnd = sq + SQ_W'(8192);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      x2_valid <= 1'b0;
    end else if (en) begin
      sq_valid <= bus_in.valid;
      x2_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= SQ_W'(ax) * SQ_W'(ax);
      x2 <= sq_rnd[14 +: X2_W];
    end
  end

  assign bus_out = '{valid: x2_valid, x2: x2, p: P_W'(x2), t: '0, acc: ACC_INIT};

endmodule

### hw/rtl/tcos_term.sv
`timescale 1ns / 1ps
// series stage k: next power, term k product, and accumulation of term k-1
module tcos_term import tcos_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [KW-1:0] k,
  input  term_bus_t     bus_in,
  output term_bus_t     bus_out
);

  logic [P_W+X2_W-1:0]     p_prod;
  logic [P_W+X2_W-1:0]     p_rnd;
  logic [P_W+C_W-1:0]      t_prod;
  logic [ACC_W-1:0]        t_ext;
  logic signed [ACC_W-1:0] acc_next;

  logic                    valid;
  logic [X2_W-1:0]         x2;
  logic [P_W-1:0]          p;
  logic [T_W-1:0]          t;
  logic signed [ACC_W-1:0] acc;

  assign p_prod = (P_W+X2_W)'(bus_in.p) * (P_W+X2_W)'(bus_in.x2);
  assign p_rnd  = p_prod + (P_W+X2_W)'(8192);
  assign t_prod = (P_W+C_W)'(bus_in.p) * (P_W+C_W)'(coef(k));
  assign t_ext  = {{(ACC_W-T_W){1'b0}}, bus_in.t};

  // previous term has odd index when k is even
  always_comb begin
    if (!k[0]) begin
      acc_next = bus_in.acc - $signed(t_ext);
    end else begin
      acc_next = bus_in.acc + $signed(t_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= bus_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2  <= bus_in.x2;
      p   <= p_rnd[14 +: P_W];
      t   <= t_prod[T_W-1:0];
      acc <= acc_next;
    end
  end

  assign bus_out = '{valid: valid, x2: x2, p: p, t: t, acc: acc};

endmodule

### hw/rtl/tcos_out.sv
`timescale 1ns / 1ps
// final accumulation, rounding to q14 and saturation into the output register
module tcos_out import tcos_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  term_bus_t               bus_in,
  output logic                    valid,
  output logic signed [COS_W-1:0] cosine
);

  localparam logic LAST_SUB = LAST_K[0];

  logic [ACC_W-1:0]        t_ext;
  logic signed [ACC_W-1:0] acc_next;
  logic                    acc_valid;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RES_W-1:0] res;
  logic signed [COS_W-1:0] cos_next;

  assign t_ext = {{(ACC_W-T_W){1'b0}}, bus_in.t};

  always_comb begin
    if (LAST_SUB) begin
      acc_next = bus_in.acc - $signed(t_ext);
    end else begin
      acc_next = bus_in.acc + $signed(t_ext);
    end
  end

  assign acc_rnd = acc + ACC_HALF;
  assign res     = acc_rnd[ACC_W-1:FRAC_SH];

  always_comb begin
    if (res > COS_MAX) begin
      cos_next = COS_MAX[COS_W-1:0];
    end else if (res < COS_MIN) begin
      cos_next = COS_MIN[COS_W-1:0];
    end else begin
      cos_next = res[COS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
      valid     <= 1'b0;
    end else if (en) begin
      acc_valid <= bus_in.valid;
      valid     <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc    <= acc_next;
      cosine <= cos_next;
    end
  end

endmodule

### hw/rtl/taylor_cosine_approx_unit.sv
`timescale 1ns / 1ps
// Cosine approximation unit: takes a Q5.14 angle in radians and returns the truncated
// Maclaurin series of its cosine in Q1.14, saturated. One angle is accepted every cycle
// while the output is not stalled. Pipeline: two range reduction stages, two
// squaring stages, one series stage per term after the first, a final accumulate stage
// and the output register. A stall on the output holds the whole pipeline in place.
module taylor_cosine_approx_unit import tcos_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // [19:0] angle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // [15:0] cosine
);

  logic                    en;
  fold_bus_t               fold_in;
  fold_bus_t               fold_mid;
  fold_bus_t               fold_done;
  term_bus_t               tb [0:NT-1];
  logic signed [COS_W-1:0] cosine;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign fold_in  = '{valid: s_tvalid, a: $signed(s_tdata[ANGLE_W-1:0])};

  tcos_fold u_fold0 (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .bus_in  (fold_in),
    .bus_out (fold_mid)
  );

  tcos_fold u_fold1 (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .bus_in  (fold_mid),
    .bus_out (fold_done)
  );

  tcos_square u_square (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .bus_in  (fold_done),
    .bus_out (tb[0])
  );

  for (genvar j = 1; j < NT; j++) begin : g_term
    tcos_term u_term (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .k       (KW'(j)),
      .bus_in  (tb[j-1]),
      .bus_out (tb[j])
    );
  end

  tcos_out u_out (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .bus_in (tb[NT-1]),
    .valid  (m_tvalid),
    .cosine (cosine)
  );

  assign m_tdata = cosine;

  // folded angle within minus pi to pi
  assert property (@(posedge clk) disable iff (rst)
    fold_done.valid |-> (fold_done.a <= Q14_PI) && (fold_done.a >= -Q14_PI))
    else $error("folded angle out of range");

  // squared angle bounded by pi squared
  assert property (@(posedge clk) disable iff (rst)
    tb[0].valid |-> tb[0].x2 <= X2_MAX)
    else $error("x squared out of range");

  // a stall freezes the first range reduction stage
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(fold_mid))
    else $error("pipeline moved during stall");

endmodule
